### rtl/core/caller_address_registry_macros.svh
// assertion helpers shared by the registry modules
// each macro expects clk and arst_n in the enclosing module
`ifndef CALLER_ADDRESS_REGISTRY_MACROS_SVH
`define CALLER_ADDRESS_REGISTRY_MACROS_SVH

// same-cycle implication
`define CRA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CRA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/cra_pkg.sv
`timescale 1ns / 1ps

package cra_pkg;

	// default sizes
	localparam int HASH_SLOTS_DEF  = 8192;
	localparam int MAX_ENTRIES_DEF = 512;

	// fixed field widths
	localparam int ADDR_W    = 32;
	localparam int CAP_W     = 10;
	localparam int IDX_OUT_W = 9;
	localparam logic [CAP_W-1:0] CAP_RESET = 10'd500;

	// result kinds
	typedef enum logic [1:0] {
		RES_HIT,
		RES_NEW,
		RES_OVF
	} res_kind_t;

	// controller to datapath commands
	typedef struct packed {
		logic      clr_wr;
		logic      start;
		logic      probe_first;
		logic      advance;
		logic      ent_rd;
		logic      insert;
		logic      load_out;
		res_kind_t kind;
	} cra_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic hash_done;
		logic slot_empty;
		logic ent_match;
		logic probe_last;
		logic limit;
		logic out_busy;
	} cra_sts_t;

endpackage

### rtl/core/cra_ram.sv
`timescale 1ns / 1ps

module cra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/cra_hash.sv
`timescale 1ns / 1ps

module cra_hash
	import cra_pkg::*;
#(
	parameter int HASH_SLOTS = HASH_SLOTS_DEF,
	localparam int SLOT_W = $clog2(HASH_SLOTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ADDR_W-1:0] addr,
	output logic              done,
	output logic [SLOT_W-1:0] slot
);

	localparam bit SLOTS_POW2 = (HASH_SLOTS == (1 << SLOT_W));

	if (SLOTS_POW2) begin : g_mask
		logic [SLOT_W-1:0] slot_q;

		// home slot is the low address bits
		always_ff @(posedge clk) begin
			if (start) begin
				slot_q <= addr[SLOT_W-1:0];
			end
		end

		assign done = 1'b1;
		assign slot = slot_q;
	end else begin : g_recip
		localparam int SHIFT  = ADDR_W - 1 + SLOT_W;
		localparam int PROD_W = 2 * ADDR_W;
		localparam int QUOT_W = PROD_W - SHIFT;
		localparam logic [PROD_W-1:0] RECIP_FULL = (PROD_W'(1) << SHIFT) / PROD_W'(HASH_SLOTS);
		localparam logic [ADDR_W-1:0] RECIP = RECIP_FULL[ADDR_W-1:0];
		localparam logic [SLOT_W:0]   SLOTS_EXT = (SLOT_W + 1)'(HASH_SLOTS);

		logic [1:0]        stage_q;
		logic [ADDR_W-1:0] addr_q;
		logic [PROD_W-1:0] prod_s1;
		logic [SLOT_W:0]   rem_s2;
		logic [QUOT_W-1:0] quot;
		logic [ADDR_W-1:0] quot_mul;
		logic [ADDR_W-1:0] rem_raw;

		// two stage marker, done once the remainder register is loaded
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_q <= '0;
			end else if (start) begin
				stage_q <= 2'b01;
			end else begin
				stage_q <= {stage_q[0], 1'b0};
			end
		end

		// quotient estimate by reciprocal, low by at most one
		always_ff @(posedge clk) begin
			if (start) begin
				addr_q <= addr;
			end
			prod_s1 <= PROD_W'(addr_q) * PROD_W'(RECIP);
			rem_s2  <= rem_raw[SLOT_W:0];
		end

		assign quot     = prod_s1[PROD_W-1:SHIFT];
		assign quot_mul = ADDR_W'(quot) * ADDR_W'(HASH_SLOTS);
		assign rem_raw  = addr_q - quot_mul;

		// one compare and subtract brings the remainder into range
		assign done = (stage_q == 2'b00);
		assign slot = (rem_s2 >= SLOTS_EXT) ? SLOT_W'(rem_s2 - SLOTS_EXT) : rem_s2[SLOT_W-1:0];
	end

endmodule

### rtl/core/cra_datapath.sv
`timescale 1ns / 1ps
`include "caller_address_registry_macros.svh"

module cra_datapath
	import cra_pkg::*;
#(
	parameter int HASH_SLOTS  = HASH_SLOTS_DEF,
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cra_cmd_t          cmd,
	output cra_sts_t          sts,
	input  logic [ADDR_W-1:0] in_data,
	input  logic              cfg_wr,
	input  logic [CAP_W-1:0]  cfg_data,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,
	output logic [1:0]        m_tuser
);

	localparam int SLOT_W = $clog2(HASH_SLOTS);
	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int NXT_W  = IDX_W + 1;
	localparam int CMP_W  = (NXT_W > CAP_W) ? NXT_W : CAP_W;
	localparam int WID_W  = IDX_W + IDX_OUT_W;

	logic [ADDR_W-1:0]    addr_q;
	logic [SLOT_W-1:0]    p_q;
	logic [SLOT_W-1:0]    n_q;
	logic [IDX_W-1:0]     ix_q;
	logic [IDX_W-1:0]     count_q;
	logic [CAP_W-1:0]     cap_q;
	logic [SLOT_W-1:0]    clr_q;
	logic                 out_valid_q;
	logic [IDX_OUT_W-1:0] out_idx_q;
	logic                 out_new_q;
	logic                 out_ovf_q;

	logic              hash_done;
	logic [SLOT_W-1:0] hash_slot;
	logic [SLOT_W-1:0] p_next;
	logic              slot_re;
	logic [SLOT_W-1:0] slot_raddr;
	logic              slot_we;
	logic [SLOT_W-1:0] slot_waddr;
	logic [IDX_W-1:0]  slot_wdata;
	logic [IDX_W-1:0]  slot_rdata;
	logic [ADDR_W-1:0] ent_rdata;
	logic [NXT_W-1:0]  next_full;
	logic [IDX_W-1:0]  next_idx;
	logic [IDX_W-1:0]  res_idx;
	logic [WID_W-1:0]  res_wide;

	cra_hash #(
		.HASH_SLOTS(HASH_SLOTS)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start),
		.addr  (in_data),
		.done  (hash_done),
		.slot  (hash_slot)
	);

	// probe address with wrap
	assign p_next = (p_q == SLOT_W'(HASH_SLOTS - 1)) ? '0 : p_q + 1'b1;

	assign slot_re    = cmd.probe_first | cmd.advance;
	assign slot_raddr = cmd.probe_first ? hash_slot : p_next;

	// next index to hand out
	assign next_full = {1'b0, count_q} + 1'b1;
	assign next_idx  = next_full[IDX_W-1:0];

	// slot writes: clearing pass or insert
	assign slot_we    = cmd.clr_wr | cmd.insert;
	assign slot_waddr = cmd.clr_wr ? clr_q : p_q;
	assign slot_wdata = cmd.clr_wr ? '0 : next_idx;

	cra_ram #(
		.WIDTH(IDX_W),
		.DEPTH(HASH_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.re   (slot_re),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	cra_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(MAX_ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (cmd.insert),
		.waddr(next_idx),
		.wdata(addr_q),
		.re   (cmd.ent_rd),
		.raddr(slot_rdata),
		.rdata(ent_rdata)
	);

	// status back to the controller
	always_comb begin
		sts.clr_last   = (clr_q == SLOT_W'(HASH_SLOTS - 1));
		sts.hash_done  = hash_done;
		sts.slot_empty = (slot_rdata == '0);
		sts.ent_match  = (ent_rdata == addr_q);
		sts.probe_last = (n_q == SLOT_W'(HASH_SLOTS - 1));
		sts.limit      = (CMP_W'(next_full) >= CMP_W'(cap_q))
			|| (next_full >= NXT_W'(MAX_ENTRIES));
		sts.out_busy   = out_valid_q && !m_tready;
	end

	// result index by kind
	always_comb begin
		case (cmd.kind)
			RES_HIT: res_idx = ix_q;
			RES_NEW: res_idx = next_idx;
			RES_OVF: res_idx = count_q;
			default: res_idx = count_q;
		endcase
	end

	assign res_wide = WID_W'(res_idx);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				cap_q <= cfg_data;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.insert) begin
				count_q <= next_idx;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q <= in_data;
		end
		if (cmd.probe_first) begin
			p_q <= hash_slot;
			n_q <= '0;
		end else if (cmd.advance) begin
			p_q <= p_next;
			n_q <= n_q + 1'b1;
		end
		if (cmd.ent_rd) begin
			ix_q <= slot_rdata;
		end
		if (cmd.load_out) begin
			out_idx_q <= res_wide[IDX_OUT_W-1:0];
			out_new_q <= (cmd.kind == RES_NEW);
			out_ovf_q <= (cmd.kind == RES_OVF);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(16 - IDX_OUT_W){1'b0}}, out_idx_q};
	assign m_tuser  = {out_ovf_q, out_new_q};

	`CRA_ASSERT_NEXT(a_insert_count, cmd.insert, count_q == $past(next_idx), "count did not step on insert")
	`CRA_ASSERT_NEXT(a_out_source, !out_valid_q && !cmd.load_out, !out_valid_q, "result shown without a load")

endmodule

### rtl/core/cra_ctrl.sv
`timescale 1ns / 1ps
`include "caller_address_registry_macros.svh"

module cra_ctrl
	import cra_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  cra_sts_t sts,
	output cra_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_SLOT,
		S_ENTRY
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// commands and next state
	always_comb begin
		cmd     = '0;
		cmd.kind = RES_HIT;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_HASH;
				end
			end
			S_HASH: begin
				if (sts.hash_done) begin
					cmd.probe_first = 1'b1;
					state_d         = S_SLOT;
				end
			end
			S_SLOT: begin
				// empty slot ends the probe as a miss
				if (sts.slot_empty) begin
					if (!sts.out_busy) begin
						cmd.load_out = 1'b1;
						cmd.kind     = sts.limit ? RES_OVF : RES_NEW;
						cmd.insert   = !sts.limit;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.ent_rd = 1'b1;
					state_d    = S_ENTRY;
				end
			end
			S_ENTRY: begin
				if (sts.ent_match) begin
					if (!sts.out_busy) begin
						cmd.load_out = 1'b1;
						cmd.kind     = RES_HIT;
						state_d      = S_IDLE;
					end
				end else if (sts.probe_last) begin
					// whole table probed with no empty slot
					if (!sts.out_busy) begin
						cmd.load_out = 1'b1;
						cmd.kind     = RES_OVF;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_SLOT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`CRA_ASSERT_IMPL(a_load_free, cmd.load_out, !sts.out_busy, "result loaded over a waiting one")
	`CRA_ASSERT_IMPL(a_insert_ok, cmd.insert, sts.slot_empty && !sts.limit, "insert without room")
	`CRA_ASSERT_NEXT(a_entry_follows, cmd.ent_rd, state_q == S_ENTRY, "entry read not checked")

endmodule

### rtl/core/caller_address_registry.sv
`timescale 1ns / 1ps

// caller address registry
// maps a 32-bit caller address to a small caller index through a hash table
// input channel s_*: one caller address per transfer
// output channel m_*: one result per input, index in m_tdata, flags in m_tuser
// config channel cfg_*: capacity limit, always ready; the user must see that it is
// written while idle, as the block itself does not enforce this
// an input transfer starts the hash, then the home slot is read; the result
// loads when that slot is empty, or after an entry read when it holds the
// address; each further slot table probe adds a slot read then an entry read
// one item at a time; s_tready returns the cycle after the result loads
// a slot count that is not a power of two adds the product and remainder
// registers of the hash before the home slot is read
// reset: the slot table is cleared one slot a cycle, with s_tready low;
// config transfers are taken during the clear
// stall: a held result sits in the output register while the next input
// is accepted and probed; the block waits only when its result is ready
module caller_address_registry
	import cra_pkg::*;
#(
	parameter int HASH_SLOTS  = HASH_SLOTS_DEF,
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [ADDR_W-1:0] s_tdata,   // caller_address[31:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // caller_index[8:0], zeros above
	output logic [1:0]        m_tuser,   // was_new[0], overflow[1]
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CAP_W-1:0]  cfg_data   // capacity_limit
);

	cra_cmd_t cmd;
	cra_sts_t sts;

	assign cfg_ready = 1'b1;

	cra_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	cra_datapath #(
		.HASH_SLOTS (HASH_SLOTS),
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_data (s_tdata),
		.cfg_wr  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cra_pkg::*;

	// pacing of the two streams
	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SEND_GAPS,
		PACE_RECV_STALLS,
		PACE_BOTH
	} pace_t;

	// directed table row kinds
	typedef enum logic {
		ROW_LOOKUP,
		ROW_LIMIT
	} row_kind_t;

	// result flags as carried in m_tuser
	localparam int FLAG_NEW_BIT = 0;
	localparam int FLAG_OVF_BIT = 1;
	localparam logic [1:0] FL_HIT = 2'b00;
	localparam logic [1:0] FL_NEW = 2'b01;
	localparam logic [1:0] FL_OVF = 2'b10;

	localparam int HOME_W      = $clog2(HASH_SLOTS_DEF);
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 230;
	localparam int HOLD_CYCLES = 300;
	localparam int PRINT_LIMIT = 40;

	typedef struct {
		logic [15:0] idx;
		logic [1:0]  flags;
	} lookup_result_t;

	typedef struct {
		row_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [CAP_W-1:0]  limit;
		bit                typed;
		lookup_result_t    want;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [ADDR_W-1:0] s_tdata = '0;      // caller_address[31:0]
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;           // caller_index[8:0], zeros above
	logic [1:0]        m_tuser;           // was_new[0], overflow[1]
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CAP_W-1:0]  cfg_data = '0;     // capacity_limit

	// registry state as predicted
	logic [IDX_OUT_W-1:0] slot_model [HASH_SLOTS_DEF];
	logic [ADDR_W-1:0]    entry_model [MAX_ENTRIES_DEF];
	int unsigned          last_index = 0;
	logic [CAP_W-1:0]     limit_model = CAP_RESET;

	lookup_result_t    pending_results[$];
	logic [ADDR_W-1:0] seen_addresses[$];
	dir_row_t          directed[$];

	logic [CAP_W-1:0] phase_limits [PHASES] = '{10'd60, 10'd0, 10'd200, 10'd1,
		10'd350, 10'd2, 10'd1023, 10'd512};

	pace_t pace = PACE_FULL;
	int    errors = 0;
	int    sent_count = 0;
	int    hit_count = 0;
	int    new_count = 0;
	int    ovf_count = 0;
	int    hold_asked = 0;
	int    hold_given = 0;
	int    hold_left = 0;

	caller_address_registry u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// lookup with linear probing, insert on miss while below the limit
	function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
		lookup_result_t r;
		int unsigned slot;
		int unsigned ix;
		int unsigned nxt;
		bit found_empty;
		slot = addr % HASH_SLOTS_DEF;
		found_empty = 1'b0;
		for (int n = 0; n < HASH_SLOTS_DEF; n++) begin
			ix = slot_model[slot];
			if (ix == 0) begin
				found_empty = 1'b1;
				break;
			end
			if (entry_model[ix] == addr) begin
				r.idx = 16'(ix);
				r.flags = FL_HIT;
				return r;
			end
			slot = (slot + 1 == HASH_SLOTS_DEF) ? 0 : slot + 1;
		end
		nxt = last_index + 1;
		if (nxt >= limit_model || nxt >= MAX_ENTRIES_DEF || !found_empty) begin
			r.idx = 16'(last_index);
			r.flags = FL_OVF;
			return r;
		end
		last_index = nxt;
		slot_model[slot] = IDX_OUT_W'(nxt);
		entry_model[nxt] = addr;
		r.idx = 16'(nxt);
		r.flags = FL_NEW;
		return r;
	endfunction

	function automatic bit send_gap();
		case (pace)
			PACE_SEND_GAPS: return $urandom_range(99) < 68;
			PACE_BOTH:      return $urandom_range(99) < 25;
			default:        return 1'b0;
		endcase
	endfunction

	function automatic bit recv_stall();
		case (pace)
			PACE_RECV_STALLS: return $urandom_range(99) < 68;
			PACE_BOTH:        return $urandom_range(99) < 25;
			default:          return 1'b0;
		endcase
	endfunction

	// mostly repeats and home-slot collisions, some near the wrap point
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned r;
		logic [ADDR_W-1:0] u;
		logic [ADDR_W-1:0] base;
		r = $urandom_range(99);
		u = $urandom;
		if (seen_addresses.size() != 0)
			base = seen_addresses[$urandom_range(seen_addresses.size() - 1)];
		else
			base = $urandom;
		if (r < 40)
			return base;
		if (r < 60)
			return {u[ADDR_W-1:HOME_W], base[HOME_W-1:0]};
		if (r < 70)
			return {u[ADDR_W-1:HOME_W], HOME_W'(HASH_SLOTS_DEF - 1 - $urandom_range(7))};
		return u;
	endfunction

	// one address transfer, expectation queued at acceptance
	task automatic send_address(input logic [ADDR_W-1:0] addr, input bit typed,
		input lookup_result_t typed_res);
		lookup_result_t r;
		if (send_gap()) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (send_gap());
		end
		s_tvalid <= 1'b1;
		s_tdata <= addr;
		do @(posedge clk); while (!s_tready);
		r = predict_lookup(addr);
		pending_results.push_back(typed ? typed_res : r);
		seen_addresses.push_back(addr);
		sent_count++;
	endtask

	// stop sending until every result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_limit(input logic [CAP_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_model = value;
	endtask

	// result check and output back-pressure
	always @(posedge clk) begin : result_side
		lookup_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (m_tuser == FL_NEW)
				new_count++;
			else if (m_tuser == FL_OVF)
				ovf_count++;
			else
				hit_count++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors < PRINT_LIMIT)
					$display("%0t: unexpected result, got tdata=%h tuser=%b",
						$time, m_tdata, m_tuser);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.idx) begin
					errors++;
					if (errors < PRINT_LIMIT)
						$display("%0t: caller_index expected %0d, got %0d",
							$time, want.idx, m_tdata);
				end
				if (m_tuser[FLAG_NEW_BIT] !== want.flags[FLAG_NEW_BIT]) begin
					errors++;
					if (errors < PRINT_LIMIT)
						$display("%0t: was_new expected %b, got %b", $time,
							want.flags[FLAG_NEW_BIT], m_tuser[FLAG_NEW_BIT]);
				end
				if (m_tuser[FLAG_OVF_BIT] !== want.flags[FLAG_OVF_BIT]) begin
					errors++;
					if (errors < PRINT_LIMIT)
						$display("%0t: overflow expected %b, got %b", $time,
							want.flags[FLAG_OVF_BIT], m_tuser[FLAG_OVF_BIT]);
				end
			end
		end
		// long hold-off on request, else random stalls
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_given) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_given <= hold_given + 1;
		end else begin
			m_tready <= !recv_stall();
		end
	end

	// run limit
	initial begin
		#50_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// stimulus
	initial begin
		for (int i = 0; i < HASH_SLOTS_DEF; i++)
			slot_model[i] = '0;
		for (int i = 0; i < MAX_ENTRIES_DEF; i++)
			entry_model[i] = '0;

		// directed: collisions, wrap, hits, and the low limits
		directed.push_back('{ROW_LOOKUP, 32'h0000_0000, '0, 1'b1, '{16'd1, FL_NEW}});
		directed.push_back('{ROW_LOOKUP, 32'h0000_0000, '0, 1'b1, '{16'd1, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'h0000_2000, '0, 1'b1, '{16'd2, FL_NEW}});
		directed.push_back('{ROW_LOOKUP, 32'hFFFF_FFFF, '0, 1'b1, '{16'd3, FL_NEW}});
		directed.push_back('{ROW_LOOKUP, 32'h0000_1FFF, '0, 1'b1, '{16'd4, FL_NEW}});
		directed.push_back('{ROW_LOOKUP, 32'h0000_2000, '0, 1'b1, '{16'd2, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'h8000_0000, '0, 1'b1, '{16'd5, FL_NEW}});
		directed.push_back('{ROW_LOOKUP, 32'hFFFF_FFFF, '0, 1'b1, '{16'd3, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'h0000_1FFF, '0, 1'b1, '{16'd4, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'hAAAA_AAAA, '0, 1'b0, '{16'd0, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'h5555_5555, '0, 1'b0, '{16'd0, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'h0000_0001, '0, 1'b0, '{16'd0, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'h1234_5678, '0, 1'b0, '{16'd0, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'h1234_5678, '0, 1'b0, '{16'd0, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'hFFFF_E000, '0, 1'b0, '{16'd0, FL_HIT}});
		directed.push_back('{ROW_LIMIT, '0, 10'd2, 1'b0, '{16'd0, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'hDEAD_BEEF, '0, 1'b0, '{16'd0, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'h0000_0000, '0, 1'b1, '{16'd1, FL_HIT}});
		directed.push_back('{ROW_LIMIT, '0, 10'd0, 1'b0, '{16'd0, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'h0BAD_F00D, '0, 1'b0, '{16'd0, FL_HIT}});
		directed.push_back('{ROW_LIMIT, '0, 10'd1, 1'b0, '{16'd0, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'h0000_0000, '0, 1'b1, '{16'd1, FL_HIT}});
		directed.push_back('{ROW_LOOKUP, 32'h0000_CAFE, '0, 1'b0, '{16'd0, FL_HIT}});

		// reset
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_LIMIT) begin
				drain_results();
				write_limit(directed[i].limit);
			end else begin
				send_address(directed[i].addr, directed[i].typed, directed[i].want);
			end
		end

		// random phases, one limit and one pacing mode each
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			write_limit(phase_limits[ph]);
			pace = pace_t'(ph % 4);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 0 && k == 40)
					hold_asked++;
				if (ph == 5 && k == 120)
					drain_results();
				send_address(pick_address(), 1'b0, '{16'd0, FL_HIT});
			end
		end

		drain_results();
		repeat (50) @(posedge clk);

		$display("%0d lookups over limits 0 to 1023 and four pacing modes", sent_count);
		$display("%0d hits, %0d inserts, %0d overflows, %0d entries at end",
			hit_count, new_count, ovf_count, last_index);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/cra_pkg.sv
rtl/core/cra_ram.sv
rtl/core/cra_hash.sv
rtl/core/cra_datapath.sv
rtl/core/cra_ctrl.sv
rtl/core/caller_address_registry.sv
tb/sv/testbench.sv
